>>> rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg - shared types and constants of the pending request timeout table
// command and status codes, sequencer states, slot word layout
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int unsigned DEFAULT_TABLE_DEPTH = 16;
   localparam int unsigned MAX_RESULTS         = 16;
   localparam int unsigned CNT_W               = $clog2(MAX_RESULTS + 1);

   localparam int unsigned CMD_W     = 2;
   localparam int unsigned KEY_W     = 32;
   localparam int unsigned PAYLOAD_W = 16;
   localparam int unsigned TIMEOUT_W = 32;
   localparam int unsigned STATUS_W  = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_EXPIRED   = 3'd5,
      ST_LISTED    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_DONE = 2'd2
   } state_type;

   // one slot as stored in the slot memory
   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic [TIMEOUT_W-1:0] countdown;
   } slot_word_type;

   localparam int unsigned SLOT_W = $bits(slot_word_type);

   // verdict of the shared slot unit for the slot under scan
   typedef struct packed {
      logic                 live;
      logic                 key_hit;
      logic                 expire;
      logic [TIMEOUT_W-1:0] countdown_dec;
   } slot_eval_type;

endpackage

>>> rtl/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram - generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ptt_ram #(
   parameter  int unsigned WIDTH  = 8,
   parameter  int unsigned DEPTH  = 16,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ptt_slot_alu.sv
// ----------------------------------------------------------------------------
// ptt_slot_alu - shared compare and decrement unit
// judges one slot per cycle: key match, expiry, aged countdown
// ----------------------------------------------------------------------------
module ptt_slot_alu (
   input  logic                          slot_live,
   input  ptt_pkg::slot_word_type        slot_word,
   input  logic [ptt_pkg::KEY_W-1:0]     req_key,
   output ptt_pkg::slot_eval_type        eval
);
   import ptt_pkg::*;

   always_comb begin
      eval.live          = slot_live;
      eval.key_hit       = slot_live && (slot_word.key == req_key);
      eval.expire        = slot_live && (slot_word.countdown <= TIMEOUT_W'(1));
      eval.countdown_dec = slot_word.countdown - TIMEOUT_W'(1);
   end

endmodule

>>> rtl/pending_request_timeout_table.sv
// ----------------------------------------------------------------------------
// pending_request_timeout_table - table of outstanding requests with timeout
// insert, remove, tick aging and key listing over a slot scan
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command scans
// all TABLE_DEPTH slots, one slot per cycle through the single read port of
// the slot memory, so busy stays high from the accept through the scan and
// the done state, and no new command is taken until that command is done.
// Results come out on rsp_* for exactly one cycle each, marked by rsp_strobe,
// in slot order; the receiver must take them as they come. Insert and remove
// give one result each. Tick gives one result per expired entry and list one
// per valid key, at most MAX_RESULTS each, and nothing when there is nothing
// to report. rsp_last marks the final result of a command. The slot valid
// bits clear at reset; slot contents need no clearing pass.
// ----------------------------------------------------------------------------
module pending_request_timeout_table #(
   parameter int unsigned TABLE_DEPTH = ptt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // command side
   input  logic                              start,
   output logic                              busy,
   input  logic [ptt_pkg::CMD_W-1:0]         req_command,
   input  logic [ptt_pkg::KEY_W-1:0]         req_key,
   input  logic [ptt_pkg::PAYLOAD_W-1:0]     req_payload,
   input  logic [ptt_pkg::TIMEOUT_W-1:0]     req_timeout_ticks,
   // result side
   output logic                              rsp_strobe,
   output logic [ptt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ptt_pkg::KEY_W-1:0]         rsp_key_res,
   output logic [ptt_pkg::PAYLOAD_W-1:0]     rsp_payload_res,
   output logic                              rsp_last
);
   import ptt_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   // sequencer and scan pipeline
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      issue_idx_ff, issue_idx_in;
   logic                  issue_done_ff, issue_done_in;
   logic                  proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]      proc_idx_ff, proc_idx_in;

   // latched command item
   cmd_type               cmd_ff, cmd_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [PAYLOAD_W-1:0]  payload_ff, payload_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;

   // slot valid bits
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   // lookup results gathered over the scan
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [PAYLOAD_W-1:0]  hit_payload_ff, hit_payload_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;

   // result count and one held-back result, so last can be set on the final one
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  pend_valid_ff, pend_valid_in;
   status_type            pend_status_ff, pend_status_in;
   logic [KEY_W-1:0]      pend_key_ff, pend_key_in;
   logic [PAYLOAD_W-1:0]  pend_payload_ff, pend_payload_in;

   // result output register
   logic                  rsp_strobe_ff, rsp_strobe_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]      rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_W-1:0]  rsp_payload_ff, rsp_payload_in;
   logic                  rsp_last_ff, rsp_last_in;

   // slot memory
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   slot_word_type         ram_wr_word;
   logic                  ram_rd_en;
   logic [SLOT_W-1:0]     ram_rd_data;
   slot_word_type         rd_word;
   slot_eval_type         eval;

   // new result found while scanning
   logic                  new_res;
   status_type            new_status;
   logic [KEY_W-1:0]      new_key;
   logic [PAYLOAD_W-1:0]  new_payload;

   ptt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_word = slot_word_type'(ram_rd_data);

   ptt_slot_alu u_slot_alu (
      .slot_live (valid_ff[proc_idx_ff]),
      .slot_word (rd_word),
      .req_key   (key_ff),
      .eval      (eval)
   );

   always_comb begin
      state_in        = state_ff;
      issue_idx_in    = issue_idx_ff;
      issue_done_in   = issue_done_ff;
      proc_valid_in   = 1'b0;
      proc_idx_in     = proc_idx_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      payload_in      = payload_ff;
      timeout_in      = timeout_ff;
      valid_in        = valid_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_payload_in  = hit_payload_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      cnt_in          = cnt_ff;
      pend_valid_in   = pend_valid_ff;
      pend_status_in  = pend_status_ff;
      pend_key_in     = pend_key_ff;
      pend_payload_in = pend_payload_ff;
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_key_in      = rsp_key_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_last_in     = 1'b0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = proc_idx_ff;
      ram_wr_word     = '{key: rd_word.key, payload: rd_word.payload,
                          countdown: eval.countdown_dec};
      ram_rd_en       = 1'b0;
      new_res         = 1'b0;
      new_status      = ST_LISTED;
      new_key         = rd_word.key;
      new_payload     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in        = cmd_type'(req_command);
               key_in        = req_key;
               payload_in    = req_payload;
               // a zero timeout behaves as one tick
               timeout_in    = (req_timeout_ticks == '0) ? TIMEOUT_W'(1) : req_timeout_ticks;
               issue_idx_in  = '0;
               issue_done_in = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = S_SCAN;
            end
         end

         S_SCAN: begin
            // read side: one slot address per cycle
            if (!issue_done_ff) begin
               ram_rd_en     = 1'b1;
               proc_valid_in = 1'b1;
               proc_idx_in   = issue_idx_ff;
               if (issue_idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  issue_idx_in = issue_idx_ff + IDX_W'(1);
               end
            end

            // process side: slot read in the previous cycle
            if (proc_valid_ff) begin
               unique case (cmd_ff)
                  CMD_INSERT, CMD_REMOVE: begin
                     if (eval.key_hit && !hit_ff) begin
                        hit_in         = 1'b1;
                        hit_idx_in     = proc_idx_ff;
                        hit_payload_in = rd_word.payload;
                     end
                     if (!eval.live && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = proc_idx_ff;
                     end
                  end
                  CMD_TICK: begin
                     if (eval.expire) begin
                        // past the result limit the entry waits for a later tick
                        if (cnt_ff < CNT_W'(MAX_RESULTS)) begin
                           valid_in[proc_idx_ff] = 1'b0;
                           new_res     = 1'b1;
                           new_status  = ST_EXPIRED;
                           new_payload = rd_word.payload;
                        end
                     end else if (eval.live) begin
                        ram_wr_en = 1'b1;
                     end
                  end
                  CMD_LIST: begin
                     if (eval.live && (cnt_ff < CNT_W'(MAX_RESULTS))) begin
                        new_res    = 1'b1;
                        new_status = ST_LISTED;
                     end
                  end
               endcase

               if (new_res) begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  // a newer result shows the held one is not the final one
                  if (pend_valid_ff) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_status_in  = pend_status_ff;
                     rsp_key_in     = pend_key_ff;
                     rsp_payload_in = pend_payload_ff;
                     rsp_last_in    = 1'b0;
                  end
                  pend_valid_in   = 1'b1;
                  pend_status_in  = new_status;
                  pend_key_in     = new_key;
                  pend_payload_in = new_payload;
               end

               if (proc_idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
            unique case (cmd_ff)
               CMD_INSERT: begin
                  rsp_strobe_in  = 1'b1;
                  rsp_key_in     = key_ff;
                  rsp_payload_in = '0;
                  rsp_last_in    = 1'b1;
                  if (hit_ff) begin
                     rsp_status_in = ST_DUPLICATE;
                  end else if (free_found_ff) begin
                     rsp_status_in         = ST_INSERTED;
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     ram_wr_word           = '{key: key_ff, payload: payload_ff,
                                               countdown: timeout_ff};
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end
               CMD_REMOVE: begin
                  rsp_strobe_in = 1'b1;
                  rsp_key_in    = key_ff;
                  rsp_last_in   = 1'b1;
                  if (hit_ff) begin
                     rsp_status_in        = ST_REMOVED;
                     rsp_payload_in       = hit_payload_ff;
                     valid_in[hit_idx_ff] = 1'b0;
                  end else begin
                     rsp_status_in  = ST_NOT_FOUND;
                     rsp_payload_in = '0;
                  end
               end
               CMD_TICK, CMD_LIST: begin
                  // the held result, if any, is the final one
                  if (pend_valid_ff) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_status_in  = pend_status_ff;
                     rsp_key_in     = pend_key_ff;
                     rsp_payload_in = pend_payload_ff;
                     rsp_last_in    = 1'b1;
                  end
                  pend_valid_in = 1'b0;
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_done_ff <= 1'b0;
         proc_valid_ff <= 1'b0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         proc_valid_ff <= proc_valid_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      issue_idx_ff    <= issue_idx_in;
      proc_idx_ff     <= proc_idx_in;
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      payload_ff      <= payload_in;
      timeout_ff      <= timeout_in;
      hit_ff          <= hit_in;
      hit_idx_ff      <= hit_idx_in;
      hit_payload_ff  <= hit_payload_in;
      free_found_ff   <= free_found_in;
      free_idx_ff     <= free_idx_in;
      cnt_ff          <= cnt_in;
      pend_status_ff  <= pend_status_in;
      pend_key_ff     <= pend_key_in;
      pend_payload_ff <= pend_payload_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_key_ff      <= rsp_key_in;
      rsp_payload_ff  <= rsp_payload_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_key_res     = rsp_key_ff;
   assign rsp_payload_res = rsp_payload_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> sim/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker - result checker for the pending request timeout table
// mirrors the slot table from accepted commands and compares every result
// ----------------------------------------------------------------------------
module ptt_checker #(
   parameter int unsigned TABLE_DEPTH = ptt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [ptt_pkg::CMD_W-1:0]     req_command,
   input  logic [ptt_pkg::KEY_W-1:0]     req_key,
   input  logic [ptt_pkg::PAYLOAD_W-1:0] req_payload,
   input  logic [ptt_pkg::TIMEOUT_W-1:0] req_timeout_ticks,
   input  logic                          rsp_strobe,
   input  logic [ptt_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [ptt_pkg::KEY_W-1:0]     rsp_key_res,
   input  logic [ptt_pkg::PAYLOAD_W-1:0] rsp_payload_res,
   input  logic                          rsp_last,
   output int unsigned                   mismatches,
   output int unsigned                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import ptt_pkg::*;

   typedef struct packed {
      status_type           status;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic                 last;
   } rsp_item_type;

   // shadow copy of the slot table
   logic                 tbl_valid     [TABLE_DEPTH];
   logic [KEY_W-1:0]     tbl_key       [TABLE_DEPTH];
   logic [PAYLOAD_W-1:0] tbl_payload   [TABLE_DEPTH];
   logic [TIMEOUT_W-1:0] tbl_countdown [TABLE_DEPTH];

   rsp_item_type expected_results [$];
   int unsigned  error_count = 0;

   function automatic int find_slot(input logic [KEY_W-1:0] key);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (tbl_valid[i] && tbl_key[i] == key) return i;
      end
      return -1;
   endfunction

   task automatic apply_command(input cmd_type cmd, input logic [KEY_W-1:0] key,
                                input logic [PAYLOAD_W-1:0] payload,
                                input logic [TIMEOUT_W-1:0] timeout);
      rsp_item_type batch [MAX_RESULTS];
      int n;
      int slot;
      n = 0;
      case (cmd)
         CMD_INSERT: begin
            if (find_slot(key) >= 0) begin
               batch[n++] = '{status: ST_DUPLICATE, key: key, payload: '0, last: 1'b0};
            end else begin
               slot = -1;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (!tbl_valid[i] && slot < 0) slot = i;
               end
               if (slot < 0) begin
                  batch[n++] = '{status: ST_FULL, key: key, payload: '0, last: 1'b0};
               end else begin
                  tbl_valid[slot]     = 1'b1;
                  tbl_key[slot]       = key;
                  tbl_payload[slot]   = payload;
                  // zero timeout behaves as one tick
                  tbl_countdown[slot] = (timeout == '0) ? TIMEOUT_W'(1) : timeout;
                  batch[n++] = '{status: ST_INSERTED, key: key, payload: '0, last: 1'b0};
               end
            end
         end
         CMD_REMOVE: begin
            slot = find_slot(key);
            if (slot < 0) begin
               batch[n++] = '{status: ST_NOT_FOUND, key: key, payload: '0, last: 1'b0};
            end else begin
               tbl_valid[slot] = 1'b0;
               batch[n++] = '{status: ST_REMOVED, key: key, payload: tbl_payload[slot],
                              last: 1'b0};
            end
         end
         CMD_TICK: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (tbl_valid[i]) begin
                  if (tbl_countdown[i] <= TIMEOUT_W'(1)) begin
                     // beyond the result limit an entry waits for a later tick
                     if (n < MAX_RESULTS) begin
                        tbl_valid[i] = 1'b0;
                        batch[n++] = '{status: ST_EXPIRED, key: tbl_key[i],
                                       payload: tbl_payload[i], last: 1'b0};
                     end
                  end else begin
                     tbl_countdown[i] = tbl_countdown[i] - TIMEOUT_W'(1);
                  end
               end
            end
         end
         default: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (tbl_valid[i] && n < MAX_RESULTS) begin
                  batch[n++] = '{status: ST_LISTED, key: tbl_key[i], payload: '0,
                                 last: 1'b0};
               end
            end
         end
      endcase
      for (int i = 0; i < n; i++) begin
         batch[i].last = (i == n - 1);
         expected_results = {expected_results, batch[i]};
      end
   endtask

   task automatic check_result();
      rsp_item_type exp;
      if (expected_results.size() == 0) begin
         if (error_count < 10)
            $display("%0t: unexpected result %0d %h %h %0d",
                     $realtime, rsp_status, rsp_key_res, rsp_payload_res, rsp_last);
         error_count++;
      end else begin
         exp = expected_results.pop_front();
         if (rsp_status !== exp.status || rsp_key_res !== exp.key ||
             rsp_payload_res !== exp.payload || rsp_last !== exp.last) begin
            if (error_count < 10)
               $display("%0t: mismatch exp %0d %h %h %0d got %0d %h %h %0d",
                        $realtime, exp.status, exp.key, exp.payload, exp.last,
                        rsp_status, rsp_key_res, rsp_payload_res, rsp_last);
            error_count++;
         end
      end
   endtask

   assign mismatches = error_count;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_strobe) check_result();
         if (start && !busy)
            apply_command(cmd_type'(req_command), req_key, req_payload, req_timeout_ticks);
      end
      outstanding <= expected_results.size();
   end

endmodule

>>> sim/pending_request_timeout_table_tb.sv
// ----------------------------------------------------------------------------
// pending_request_timeout_table_tb - testbench top of the timeout table
// directed corner cases then random command mixes over three idle profiles;
// the checker beside the block predicts and compares every result item
// ----------------------------------------------------------------------------
module pending_request_timeout_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptt_pkg::*;

   localparam int unsigned DEPTH      = DEFAULT_TABLE_DEPTH;
   localparam int unsigned POOL_SIZE  = 24;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned DRAIN_WAIT = DEPTH + 8;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [CMD_W-1:0]     req_command;
   logic [KEY_W-1:0]     req_key;
   logic [PAYLOAD_W-1:0] req_payload;
   logic [TIMEOUT_W-1:0] req_timeout_ticks;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [KEY_W-1:0]     rsp_key_res;
   logic [PAYLOAD_W-1:0] rsp_payload_res;
   logic                 rsp_last;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned idle_cycles;
   int unsigned sender_idle_pct;

   // keys drawn mostly from a small pool so that hits, duplicates and removes happen
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pending_request_timeout_table #(.TABLE_DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .req_timeout_ticks (req_timeout_ticks),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_key_res       (rsp_key_res),
      .rsp_payload_res   (rsp_payload_res),
      .rsp_last          (rsp_last)
   );

   ptt_checker #(.TABLE_DEPTH(DEPTH)) chk (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .req_timeout_ticks (req_timeout_ticks),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_key_res       (rsp_key_res),
      .rsp_payload_res   (rsp_payload_res),
      .rsp_last          (rsp_last),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   // watchdog: cycles with neither a command accept nor a result item
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // one command item: random sender idling, wait for busy low, then hold
   // start for the accepting edge; busy only moves on rising edges, so its
   // value at the falling edge decides the accept
   task automatic send_item(input cmd_type cmd, input logic [KEY_W-1:0] key,
                            input logic [PAYLOAD_W-1:0] payload,
                            input logic [TIMEOUT_W-1:0] timeout);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      while (busy) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_command       = cmd;
      req_key           = key;
      req_payload       = payload;
      req_timeout_ticks = timeout;
      start             = 1'b1;
      @(negedge clock);
      start = 1'b0;
   endtask

   // hold off new items until every expected result item has come
   task automatic wait_drained();
      start = 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 80) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [TIMEOUT_W-1:0] pick_timeout(input bit long_lived);
      int unsigned r;
      r = $urandom_range(99);
      if (long_lived) return $urandom_range(60, 20);
      if (r < 10) return '0;
      if (r < 75) return $urandom_range(8, 1);
      if (r < 90) return $urandom_range(40, 9);
      if (r < 95) return '1;
      return $urandom;
   endfunction

   // random phase: groups of items, each group either mixed, filling or draining
   task automatic random_phase(input int unsigned count);
      int unsigned mode;
      int unsigned r;
      cmd_type     cmd;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 20 == 0) mode = $urandom_range(2);
         r = $urandom_range(99);
         case (mode)
            0: cmd = (r < 40) ? CMD_INSERT : (r < 65) ? CMD_REMOVE :
                     (r < 90) ? CMD_TICK : CMD_LIST;
            1: cmd = (r < 80) ? CMD_INSERT : (r < 88) ? CMD_REMOVE :
                     (r < 94) ? CMD_TICK : CMD_LIST;
            default: cmd = (r < 40) ? CMD_REMOVE : (r < 90) ? CMD_TICK : CMD_LIST;
         endcase
         send_item(cmd, pick_key(), PAYLOAD_W'($urandom), pick_timeout(mode == 1));
      end
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_command       = CMD_INSERT;
      req_key           = '0;
      req_payload       = '0;
      req_timeout_ticks = '0;
      sender_idle_pct   = 15;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // empty table: tick and list give no result items
      send_item(CMD_LIST, '0, '0, '0);
      send_item(CMD_TICK, '0, '0, '0);
      // extremes of key, payload and timeout; zero timeout acts as one
      send_item(CMD_INSERT, '0, '0, '0);
      send_item(CMD_INSERT, '1, '1, '1);
      send_item(CMD_INSERT, '0, 16'h5a5a, 32'd3);
      send_item(CMD_TICK, '1, '1, '1);
      send_item(CMD_REMOVE, '1, '0, '0);
      send_item(CMD_REMOVE, '1, '0, '0);
      // fill every slot, then an insert that finds the table full
      for (int i = 0; i < DEPTH; i++)
         send_item(CMD_INSERT, KEY_W'(32'h8000_0000 | i), PAYLOAD_W'(i * 16'h1111),
                   TIMEOUT_W'(1 + (i % 2)));
      send_item(CMD_INSERT, 32'h1234_5678, 16'hbeef, 32'd5);
      send_item(CMD_LIST, '0, '0, '0);
      // half the slots expire together
      send_item(CMD_TICK, '0, '0, '0);
      wait_drained();

      random_phase(150);
      wait_drained();
      sender_idle_pct = 68;
      random_phase(150);
      wait_drained();
      sender_idle_pct = 0;
      random_phase(143);

      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
